### src/g2l_pkg.sv
// ----------------------------------------------------------------------------
// g2l_pkg
// Shared constants, year table and types for the lunar date converter.
// ----------------------------------------------------------------------------
package g2l_pkg;

    localparam int FIRST_YEAR_DEF = 1901;
    localparam int YEAR_COUNT_DEF = 199;
    localparam int NUM_CELLS      = 13;
    localparam int OFF_W          = 9;
    localparam int POS_W          = 4;

    localparam logic [23:0] YEAR_ROM [0:198] = '{
        24'h04AE53,24'h0A5748,24'h5526BD,24'h0D2650,24'h0D9544,24'h46AAB9,24'h056A4D,
        24'h09AD42,24'h24AEB6,24'h04AE4A,24'h6A4DBE,24'h0A4D52,24'h0D2546,24'h5D52BA,
        24'h0B544E,24'h0D6A43,24'h296D37,24'h095B4B,24'h749BC1,24'h049754,24'h0A4B48,
        24'h5B25BC,24'h06A550,24'h06D445,24'h4ADAB8,24'h02B64D,24'h095742,24'h2497B7,
        24'h04974A,24'h664B3E,24'h0D4A51,24'h0EA546,24'h56D4BA,24'h05AD4E,24'h02B644,
        24'h393738,24'h092E4B,24'h7C96BF,24'h0C9553,24'h0D4A48,24'h6DA53B,24'h0B554F,
        24'h056A45,24'h4AADB9,24'h025D4D,24'h092D42,24'h2C95B6,24'h0A954A,24'h7B4ABD,
        24'h06CA51,24'h0B5546,24'h555ABB,24'h04DA4E,24'h0A5B43,24'h352BB8,24'h052B4C,
        24'h8A953F,24'h0E9552,24'h06AA48,24'h6AD53C,24'h0AB54F,24'h04B645,24'h4A5739,
        24'h0A574D,24'h052642,24'h3E9335,24'h0D9549,24'h75AABE,24'h056A51,24'h096D46,
        24'h54AEBB,24'h04AD4F,24'h0A4D43,24'h4D26B7,24'h0D254B,24'h8D52BF,24'h0B5452,
        24'h0B6A47,24'h696D3C,24'h095B50,24'h049B45,24'h4A4BB9,24'h0A4B4D,24'hAB25C2,
        24'h06A554,24'h06D449,24'h6ADA3D,24'h0AB651,24'h093746,24'h5497BB,24'h04974F,
        24'h064B44,24'h36A537,24'h0EA54A,24'h86B2BF,24'h05AC53,24'h0AB647,24'h5936BC,
        24'h092E50,24'h0C9645,24'h4D4AB8,24'h0D4A4C,24'h0DA541,24'h25AAB6,24'h056A49,
        24'h7AADBD,24'h025D52,24'h092D47,24'h5C95BA,24'h0A954E,24'h0B4A43,24'h4B5537,
        24'h0AD54A,24'h955ABF,24'h04BA53,24'h0A5B48,24'h652BBC,24'h052B50,24'h0A9345,
        24'h474AB9,24'h06AA4C,24'h0AD541,24'h24DAB6,24'h04B64A,24'h69573D,24'h0A4E51,
        24'h0D2646,24'h5E933A,24'h0D534D,24'h05AA43,24'h36B537,24'h096D4B,24'hB4AEBF,
        24'h04AD53,24'h0A4D48,24'h6D25BC,24'h0D254F,24'h0D5244,24'h5DAA38,24'h0B5A4C,
        24'h056D41,24'h24ADB6,24'h049B4A,24'h7A4BBE,24'h0A4B51,24'h0AA546,24'h5B52BA,
        24'h06D24E,24'h0ADA42,24'h355B37,24'h09374B,24'h8497C1,24'h049753,24'h064B48,
        24'h66A53C,24'h0EA54F,24'h06B244,24'h4AB638,24'h0AAE4C,24'h092E42,24'h3C9735,
        24'h0C9649,24'h7D4ABD,24'h0D4A51,24'h0DA545,24'h55AABA,24'h056A4E,24'h0A6D43,
        24'h452EB7,24'h052D4B,24'h8A95BF,24'h0A9553,24'h0B4A47,24'h6B553B,24'h0AD54F,
        24'h055A45,24'h4A5D38,24'h0A5B4C,24'h052B42,24'h3A93B6,24'h069349,24'h7729BD,
        24'h06AA51,24'h0AD546,24'h54DABA,24'h04B64E,24'h0A5743,24'h452738,24'h0D264A,
        24'h8E933E,24'h0D5252,24'h0DAA47,24'h66B53B,24'h056D4F,24'h04AE45,24'h4A4EB9,
        24'h0A4D4C,24'h0D1541,24'h2D92B5
    };

    localparam logic [8:0] DAYS_BEFORE [0:11] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };
    localparam logic [4:0] MONTH_DAYS [0:11] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // data handed from cell to cell
    typedef struct packed {
        logic             act;
        logic             fwd;
        logic             done;
        logic             bad;
        logic [OFF_W-1:0] off;
        logic [POS_W-1:0] pos;
    } walk_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

endpackage

### src/gregorian_to_lunar_date_core.sv
// ----------------------------------------------------------------------------
// gregorian_to_lunar_date_core
// Gregorian date to Chinese lunar month, day and leap mark, years 1901-2099.
// ----------------------------------------------------------------------------
// channel  | handshake     | signals
// input    | start / busy  | greg_year, greg_month, greg_day
// result   | done strobe   | lunar_month, lunar_day, leap_month, out_of_range
//
// An item passes through a front end that checks the date and reads the year
// table, then the chain of month cells, then a register that labels and holds
// the result, before the done strobe. busy is high from acceptance until done.
// Reset clears the controller and the chain; the receiver cannot stall.
module gregorian_to_lunar_date_core
#(
    parameter int FIRST_YEAR = g2l_pkg::FIRST_YEAR_DEF,
    parameter int YEAR_COUNT = g2l_pkg::YEAR_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] greg_year,
    input  logic [3:0]  greg_month,
    input  logic [4:0]  greg_day,
    output logic        done,
    output logic [3:0]  lunar_month,
    output logic [4:0]  lunar_day,
    output logic        leap_month,
    output logic        out_of_range
);
    import g2l_pkg::*;

    state_t           state_reg, state_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [23:0]      word_reg;
    logic [3:0]       last_reg;
    walk_t            head_reg;
    walk_t            chain [0:NUM_CELLS];
    logic [3:0]       lm_res;
    logic [3:0]       mon_res_reg;
    logic [4:0]       day_res_reg;
    logic             leap_res_reg, bad_res_reg;

    // front end
    logic [12:0]      yd;
    logic [7:0]       yi;
    logic             yok, mok, dok, gleap;
    logic [4:0]       mlen;
    logic [3:0]       mi;
    logic [23:0]      wcur, wprev;
    logic [8:0]       spring, sun;
    walk_t            head_next;
    logic [23:0]      word_next;

    always_comb
    begin
        yd    = {1'b0, greg_year} - 13'(FIRST_YEAR);
        yok   = (greg_year >= 12'(FIRST_YEAR)) && (yd < 13'(YEAR_COUNT));
        yi    = yd[7:0];
        mok   = (greg_month >= 4'd1) && (greg_month <= 4'd12);
        mi    = mok ? greg_month - 4'd1 : 4'd0;
        gleap = (greg_year[1:0] == 2'b00);
        mlen  = MONTH_DAYS[mi] + 5'((mi == 4'd1) && gleap);
        dok   = (greg_day >= 5'd1) && (greg_day <= mlen);
        wcur  = YEAR_ROM[yok ? yi : 8'd0];
        wprev = YEAR_ROM[(yok && yi != 8'd0) ? yi - 8'd1 : 8'd0];
        spring = 9'(wcur[4:0]) - 9'd1 + ((wcur[6:5] == 2'd1) ? 9'd0 : 9'd31);
        sun   = DAYS_BEFORE[mi] + 9'(greg_day) - 9'd1 + 9'(gleap && mi > 4'd1);
        head_next      = '0;
        head_next.act  = 1'b1;
        head_next.bad  = !(yok && mok && dok);
        word_next      = wcur;
        if (sun >= spring)
        begin
            head_next.fwd = 1'b1;
            head_next.off = sun - spring;
            head_next.pos = 4'd1;
        end
        else
        begin
            head_next.fwd = 1'b0;
            head_next.off = spring - sun;
            word_next     = wprev;
            head_next.pos = (wprev[23:20] != 4'd0) ? 4'd13 : 4'd12;
            if (yi == 8'd0)
                head_next.bad = 1'b1;
        end
    end

    // month length for each cell position comes from the word by position
    logic [12:0] lenbits;
    assign lenbits = word_reg[19:7];

    assign chain[0] = head_reg;

    genvar g;
    generate
        for (g = 0; g < NUM_CELLS; g++)
        begin : g_cell
            logic l30;
            always_comb
            begin
                l30 = lenbits[4'd13 - chain[g].pos];
            end
            g2l_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .din   (chain[g]),
                .len30 (l30),
                .last  (last_reg),
                .dout  (chain[g+1])
            );
        end
    endgenerate

    // controller
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_WALK;
                    cnt_next   = '0;
                end
            end
            ST_WALK:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(NUM_CELLS))
                    state_next = ST_DONE;
            end
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            head_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            head_reg  <= (state_reg == ST_IDLE && start) ? head_next : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            word_reg <= word_next;
            last_reg <= (word_next[23:20] != 4'd0) ? 4'd13 : 4'd12;
        end
    end

    // label the month position
    walk_t fin;
    logic [3:0] mon_next;
    logic [4:0] day_next;
    logic       leap_next, bad_next;
    assign fin    = chain[NUM_CELLS];
    assign lm_res = word_reg[23:20];

    always_comb
    begin
        bad_next  = fin.bad || !fin.done;
        leap_next = 1'b0;
        if (fin.fwd)
            day_next = 5'(fin.off + 9'd1);
        else
            day_next = 5'(fin.off + 9'd1);
        if (lm_res == 4'd0 || fin.pos <= lm_res)
            mon_next = fin.pos;
        else if (fin.pos == lm_res + 4'd1)
        begin
            mon_next  = lm_res;
            leap_next = 1'b1;
        end
        else
            mon_next = fin.pos - 4'd1;
        if (bad_next)
        begin
            mon_next  = '0;
            day_next  = '0;
            leap_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WALK && cnt_reg == 4'(NUM_CELLS))
        begin
            mon_res_reg  <= mon_next;
            day_res_reg  <= day_next;
            leap_res_reg <= leap_next;
            bad_res_reg  <= bad_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = (state_reg == ST_DONE);
    assign lunar_month  = mon_res_reg;
    assign lunar_day    = day_res_reg;
    assign leap_month   = leap_res_reg;
    assign out_of_range = bad_res_reg;

endmodule

### src/g2l_cell.sv
// ----------------------------------------------------------------------------
// g2l_cell
// One month step of the lunar walk: subtract one month length or stop.
// ----------------------------------------------------------------------------
module g2l_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  g2l_pkg::walk_t din,
    input  logic           len30,
    input  logic [3:0]     last,
    output g2l_pkg::walk_t dout
);
    import g2l_pkg::*;

    walk_t            dout_reg;
    walk_t            dout_next;
    logic [OFF_W-1:0] mlen;

    always_comb
    begin
        mlen      = len30 ? OFF_W'(30) : OFF_W'(29);
        dout_next = din;
        if (din.act && !din.done && !din.bad)
        begin
            if (din.fwd)
            begin
                if (din.off < mlen)
                    dout_next.done = 1'b1;
                else if (din.pos >= last)
                    dout_next.bad = 1'b1;
                else
                begin
                    dout_next.off = din.off - mlen;
                    dout_next.pos = din.pos + POS_W'(1);
                end
            end
            else
            begin
                if (din.off <= mlen)
                begin
                    dout_next.done = 1'b1;
                    dout_next.off  = mlen - din.off;
                end
                else if (din.pos <= POS_W'(1))
                    dout_next.bad = 1'b1;
                else
                begin
                    dout_next.off = din.off - mlen;
                    dout_next.pos = din.pos - POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout_reg <= '0;
        else
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

### src/g2l_checker.sv
// ----------------------------------------------------------------------------
// g2l_checker
// Port-level checks on the lunar date converter.
// ----------------------------------------------------------------------------
module g2l_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [3:0] lunar_month,
    input logic [4:0] lunar_day,
    input logic       leap_month,
    input logic       out_of_range
);
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accepted item did not raise busy");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done outside busy");

    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done) else $error("busy held after done");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_of_range) |-> (lunar_month == 4'd0 && lunar_day == 5'd0
        && !leap_month)) else $error("out of range result not cleared");

    a_ok_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !out_of_range) |-> (lunar_month != 4'd0 && lunar_day != 5'd0))
        else $error("in range result has zero month or day");
endmodule

bind gregorian_to_lunar_date_core g2l_checker u_g2l_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .lunar_month  (lunar_month),
    .lunar_day    (lunar_day),
    .leap_month   (leap_month),
    .out_of_range (out_of_range)
);

### tb/g2l_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// g2l_monitor
// Watches the date and result channels, predicts each lunar date and compares.
// ----------------------------------------------------------------------------
module g2l_monitor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [11:0] greg_year,
    input  logic [3:0]  greg_month,
    input  logic [4:0]  greg_day,
    input  logic        done,
    input  logic [3:0]  lunar_month,
    input  logic [4:0]  lunar_day,
    input  logic        leap_month,
    input  logic        out_of_range,
    output int          fail_count,
    output int          pending
);
    import g2l_pkg::*;

    typedef struct packed {
        logic [3:0] month;
        logic [4:0] day;
        logic       leap;
        logic       oor;
    } lunar_t;

    lunar_t lunar_q[$];

    function automatic int month_len(logic [23:0] w, int pos);
        return w[20 - pos] ? 30 : 29;
    endfunction

    function automatic lunar_t convert(int y, int m, int d);
        lunar_t r;
        logic   gleap;
        int     mlen, yi, spring, sun, pos, last, lm, off, back_off, day;
        logic [23:0] w;
        r = '{month: 4'd0, day: 5'd0, leap: 1'b0, oor: 1'b1};
        if (y < FIRST_YEAR_DEF || y - FIRST_YEAR_DEF >= YEAR_COUNT_DEF) return r;
        if (m < 1 || m > 12) return r;
        gleap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        mlen = MONTH_DAYS[m - 1] + ((m == 2 && gleap) ? 1 : 0);
        if (d < 1 || d > mlen) return r;
        yi = y - FIRST_YEAR_DEF;
        w = YEAR_ROM[yi];
        spring = int'(w[4:0]) - 1 + ((w[6:5] == 2'd1) ? 0 : 31);
        sun = int'(DAYS_BEFORE[m - 1]) + d - 1 + ((gleap && m > 2) ? 1 : 0);
        if (sun >= spring)
        begin
            off = sun - spring;
            lm = int'(w[23:20]);
            last = lm != 0 ? 13 : 12;
            pos = 1;
            while (off >= month_len(w, pos))
            begin
                if (pos >= last) return r;
                off -= month_len(w, pos);
                pos++;
            end
            day = off + 1;
        end
        else
        begin
            back_off = spring - sun;
            if (yi == 0) return r;
            w = YEAR_ROM[yi - 1];
            lm = int'(w[23:20]);
            pos = lm != 0 ? 13 : 12;
            while (back_off > month_len(w, pos))
            begin
                if (pos <= 1) return r;
                back_off -= month_len(w, pos);
                pos--;
            end
            day = month_len(w, pos) - back_off + 1;
        end
        if (lm == 0 || pos <= lm) r.month = 4'(pos);
        else if (pos == lm + 1)
        begin
            r.month = 4'(lm);
            r.leap = 1'b1;
        end
        else r.month = 4'(pos - 1);
        r.day = 5'(day);
        r.oor = 1'b0;
        return r;
    endfunction

    initial fail_count = 0;

    always @(posedge clk)
    begin
        lunar_t exp_r;
        lunar_t got;
        if (rst_n)
        begin
            if (done)
            begin
                got = '{lunar_month, lunar_day, leap_month, out_of_range};
                if (lunar_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected, got %p", $time, got);
                    fail_count++;
                end
                else
                begin
                    exp_r = lunar_q.pop_front();
                    if (got.month !== exp_r.month || got.day !== exp_r.day
                        || got.leap !== exp_r.leap || got.oor !== exp_r.oor)
                    begin
                        $display("%0t: mismatch, expected %p, got %p", $time, exp_r, got);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                lunar_q.push_back(convert(greg_year, greg_month, greg_day));
        end
        pending = lunar_q.size();
    end
endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives directed and random Gregorian dates into the lunar date converter.
// ----------------------------------------------------------------------------
module tb;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [11:0] greg_year = '0;
    logic [3:0]  greg_month = '0;
    logic [4:0]  greg_day = '0;
    logic        busy, done, leap_month, out_of_range;
    logic [3:0]  lunar_month;
    logic [4:0]  lunar_day;
    int          fail_count, pending;
    int          cycles = 0;

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 200000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    gregorian_to_lunar_date_core i_dut (.*);

    g2l_monitor i_checker (.*);

    // busy only moves at the rising edge, so a low busy here means acceptance
    // at the next rising edge
    task automatic send_date(int y, int m, int d);
        int gap;
        gap = $urandom_range(0, 3);
        repeat (gap) @(negedge clk);
        start      <= 1'b1;
        greg_year  <= 12'(y);
        greg_month <= 4'(m);
        greg_day   <= 5'(d);
        while (busy) @(negedge clk);
        @(negedge clk);
        start <= 1'b0;
    endtask

    initial
    begin
        int sel;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_date(1901, 1, 1);
        send_date(1901, 2, 18);
        send_date(1901, 2, 19);
        send_date(1902, 1, 1);
        send_date(2099, 12, 31);
        send_date(1900, 6, 1);
        send_date(2100, 1, 1);
        send_date(0, 0, 0);
        send_date(4095, 15, 31);
        send_date(2000, 0, 5);
        send_date(2000, 13, 5);
        send_date(2000, 2, 29);
        send_date(2001, 2, 29);
        send_date(2000, 2, 30);
        send_date(2000, 4, 31);
        send_date(2000, 5, 0);
        send_date(1903, 7, 15);
        send_date(2020, 5, 23);
        send_date(2020, 6, 21);
        send_date(2023, 3, 22);
        send_date(2033, 12, 22);
        send_date(2057, 9, 28);
        send_date(1984, 12, 31);
        repeat (900)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 8)
                send_date($urandom_range(1901, 2099), $urandom_range(1, 12),
                          $urandom_range(1, 31));
            else if (sel == 8)
                send_date($urandom_range(1901, 1902), $urandom_range(1, 3),
                          $urandom_range(1, 31));
            else
                send_date($urandom_range(0, 4095), $urandom_range(0, 15),
                          $urandom_range(0, 31));
        end
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
